// ===== design/qstg_pkg.sv =====
package qstg_pkg;

  // Queue and table sizing.
  localparam int QUEUE_DEPTH     = 16;
  localparam int IDX_W           = $clog2(QUEUE_DEPTH);
  localparam int CNT_W           = $clog2(QUEUE_DEPTH + 1);
  localparam int LENGTH_BITS     = 24;
  localparam int SINE_TABLE_BITS = 10;
  localparam int SINE_QUARTER    = 1 << (SINE_TABLE_BITS - 2);
  localparam int ROM_AW          = SINE_TABLE_BITS - 1;

  // Divider operand widths: the position ratio divides elapsed x 2^16 by the length.
  localparam int DIV_NUM_W = LENGTH_BITS + 16;
  localparam int DIV_DEN_W = LENGTH_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  localparam logic [14:0] TONE_AMPLITUDE = 15'd28000;
  localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;

  // Configuration register indexes.
  localparam logic [2:0] REG_MODE    = 3'd0;
  localparam logic [2:0] REG_CONST   = 3'd1;
  localparam logic [2:0] REG_ATTACK  = 3'd2;
  localparam logic [2:0] REG_DECAY   = 3'd3;
  localparam logic [2:0] REG_SUSTAIN = 3'd4;
  localparam logic [2:0] REG_PEAK    = 3'd5;
  localparam logic [2:0] REG_HOLD    = 3'd6;

  // Input kinds.
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_PUSH = 1'b1;

  // Quarter-wave entry k in Q0.15, from a Q30 Taylor series with truncating steps.
  // Only evaluated at elaboration to build the constant table.
  function automatic logic [14:0] quarter_sine(input int k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic [63:0] scaled;
    x = (64'(k) * HALF_PI_Q30) / SINE_QUARTER;
    x2 = (x * x) >> 30;
    term = x;
    sum = $signed(x);
    for (int n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) sum = sum - $signed(term);
      else sum = sum + $signed(term);
    end
    if (sum < 0) sum = 64'sd0;
    if (sum > 64'sd1073741824) sum = 64'sd1073741824;
    scaled = (64'(sum) * 64'd32767 + 64'd536870912) >> 30;
    return scaled[14:0];
  endfunction

endpackage

// ===== design/qstg_div.sv =====
module qstg_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [qstg_pkg::DIV_NUM_W-1:0]  num,
  input  logic [qstg_pkg::DIV_DEN_W-1:0]  den,
  output logic                            done,
  output logic [qstg_pkg::DIV_NUM_W-1:0]  quot
);

  logic [qstg_pkg::DIV_NUM_W-1:0] num_r, num_nxt;
  logic [qstg_pkg::DIV_DEN_W:0]   rem_r, rem_nxt;
  logic [qstg_pkg::DIV_DEN_W-1:0] den_r;
  logic [qstg_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [qstg_pkg::DIV_DEN_W:0]   shifted;
  logic                           fits;

  // One restoring step: shift in the next dividend bit and subtract when it fits.
  always_comb begin
    shifted  = {rem_r[qstg_pkg::DIV_DEN_W-1:0], num_r[qstg_pkg::DIV_NUM_W-1]};
    fits     = shifted >= {1'b0, den_r};
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt  = num;
      rem_nxt  = '0;
      cnt_nxt  = qstg_pkg::DIV_CNT_W'(qstg_pkg::DIV_NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? shifted - {1'b0, den_r} : shifted;
      num_nxt = {num_r[qstg_pkg::DIV_NUM_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == qstg_pkg::DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    if (start) den_r <= den;
  end

  assign done = done_r;
  assign quot = num_r;

endmodule

// ===== design/queued_sine_tone_generator.sv =====
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    kind, phase_step, note_length, note_volume
// out_      output     out_valid / out_ready  sample, sample_valid, accepted, note_done,
//                                             queue_count
// cfg_      input      cfg_we                 cfg_index, cfg_wdata
//
// A push or a tick on an empty queue goes from S_IDLE to S_OUT and then to the output register.
// A tick in constant mode passes S_RD, S_GAIN, S_MUL1, S_MUL2 and S_UPD first; in envelope mode S_DIV1,
// S_SEG and S_DIV2 follow S_RD, for two passes of the 40-step serial divider (position ratio, then
// segment slope), and S_DIV2 is skipped when the position lies in the flat segment at the hold level.
// Reset clears the queue pointers, phase and elapsed count; the note memory is
// left unwritten and no clearing pass is needed.
// The next request is taken while a result waits in the output register; a result
// that finds the output register still full waits until it drains.
module queued_sine_tone_generator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_kind,
  input  logic [31:0]                         in_phase_step,
  input  logic [qstg_pkg::LENGTH_BITS-1:0]    in_note_length,
  input  logic [15:0]                         in_note_volume,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [15:0]                  out_sample,
  output logic                                out_sample_valid,
  output logic                                out_accepted,
  output logic                                out_note_done,
  output logic [4:0]                          out_queue_count,
  input  logic                                cfg_we,
  input  logic [2:0]                          cfg_index,
  input  logic [15:0]                         cfg_wdata
);

  localparam int LB = qstg_pkg::LENGTH_BITS;
  localparam int MW = 32 + LB + 16;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_DIV1 = 4'd2;
  localparam logic [3:0] S_SEG  = 4'd3;
  localparam logic [3:0] S_DIV2 = 4'd4;
  localparam logic [3:0] S_GAIN = 4'd5;
  localparam logic [3:0] S_MUL1 = 4'd6;
  localparam logic [3:0] S_MUL2 = 4'd7;
  localparam logic [3:0] S_UPD  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  // Configuration registers.
  logic        mode_r;
  logic [15:0] const_r, attack_r, decay_r, sustain_r, peak_r, hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= 1'b0;
      const_r   <= 16'd19661;
      attack_r  <= 16'd6554;
      decay_r   <= 16'd13107;
      sustain_r <= 16'd52429;
      peak_r    <= 16'd65535;
      hold_r    <= 16'd45875;
    end else if (cfg_we) begin
      unique case (cfg_index)
        qstg_pkg::REG_MODE:    mode_r    <= cfg_wdata[0];
        qstg_pkg::REG_CONST:   const_r   <= cfg_wdata;
        qstg_pkg::REG_ATTACK:  attack_r  <= cfg_wdata;
        qstg_pkg::REG_DECAY:   decay_r   <= cfg_wdata;
        qstg_pkg::REG_SUSTAIN: sustain_r <= cfg_wdata;
        qstg_pkg::REG_PEAK:    peak_r    <= cfg_wdata;
        qstg_pkg::REG_HOLD:    hold_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Control state.
  logic [3:0]                  state_r;
  logic [qstg_pkg::IDX_W-1:0]  head_r, tail_r;
  logic [qstg_pkg::CNT_W-1:0]  count_r;
  logic [LB-1:0]               elapsed_r;
  logic [31:0]                 phase_r;
  logic                        out_valid_r;

  // Result being assembled and the output register.
  logic signed [15:0] res_sample_r;
  logic               res_svalid_r, res_acc_r, res_done_r;
  logic signed [15:0] o_sample_r;
  logic               o_svalid_r, o_acc_r, o_done_r;
  logic [4:0]         o_count_r;

  // Datapath registers.
  logic [15:0]        r_r, env_r, base_r, gain_r;
  logic               sub_r;
  logic [30:0]        prod1_r;
  logic [14:0]        mag_r;

  logic accept;
  logic push_ok;
  logic out_free;
  assign accept   = in_valid && in_ready;
  assign in_ready = state_r == S_IDLE;
  assign out_free = !out_valid_r || out_ready;
  assign push_ok  = in_note_length != '0 && count_r < qstg_pkg::CNT_W'(qstg_pkg::QUEUE_DEPTH);

  // Note memory: step, length and volume in one word, registered read at the head.
  logic [MW-1:0] qmem [0:qstg_pkg::QUEUE_DEPTH-1];
  logic [MW-1:0] rd_data_r;
  logic [31:0]   hd_step;
  logic [LB-1:0] hd_len;
  logic [15:0]   hd_vol;

  always_ff @(posedge clk) begin
    if (accept && in_kind == qstg_pkg::KIND_PUSH && push_ok)
      qmem[tail_r] <= {in_phase_step, in_note_length, in_note_volume};
    if (accept && in_kind == qstg_pkg::KIND_TICK)
      rd_data_r <= qmem[head_r];
  end

  assign hd_step = rd_data_r[MW-1 -: 32];
  assign hd_len  = rd_data_r[16 +: LB];
  assign hd_vol  = rd_data_r[15:0];

  // Quarter-wave table, read through a register from the phase.
  logic [14:0] rom_w [0:qstg_pkg::SINE_QUARTER];
  for (genvar k = 0; k <= qstg_pkg::SINE_QUARTER; k++) begin : g_rom
    assign rom_w[k] = qstg_pkg::quarter_sine(k);
  end

  logic [qstg_pkg::SINE_TABLE_BITS-1:0] sidx;
  logic [qstg_pkg::ROM_AW-1:0]          spos, saddr;
  logic [14:0]                          sine_r;
  logic                                 sneg_r;
  assign sidx  = phase_r[31 -: qstg_pkg::SINE_TABLE_BITS];
  assign spos  = {1'b0, sidx[qstg_pkg::SINE_TABLE_BITS-3:0]};
  assign saddr = sidx[qstg_pkg::SINE_TABLE_BITS-2]
               ? qstg_pkg::ROM_AW'(qstg_pkg::SINE_QUARTER) - spos : spos;

  always_ff @(posedge clk) begin
    sine_r <= rom_w[saddr];
    sneg_r <= sidx[qstg_pkg::SINE_TABLE_BITS-1];
  end

  // Shared serial divider.
  logic                           div_start;
  logic [qstg_pkg::DIV_NUM_W-1:0] div_num, div_quot;
  logic [qstg_pkg::DIV_DEN_W-1:0] div_den;
  logic                           div_done;

  qstg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Segment set-up from the position ratio.
  logic [16:0] seg_diff;
  logic [16:0] seg_mul;
  logic [16:0] seg_den;
  logic [32:0] seg_num;
  logic [15:0] seg_base;
  logic        seg_sub;
  logic        seg_flat;

  always_comb begin
    seg_flat = 1'b0;
    seg_base = '0;
    seg_sub  = 1'b0;
    seg_diff = '0;
    seg_mul  = '0;
    seg_den  = 17'd1;
    if (r_r < attack_r) begin
      seg_mul = {1'b0, peak_r};
      seg_diff = {1'b0, r_r};
      seg_den = {1'b0, attack_r};
    end else if (r_r < decay_r) begin
      seg_base = peak_r;
      seg_sub  = hold_r < peak_r;
      seg_mul  = seg_sub ? {1'b0, peak_r - hold_r} : {1'b0, hold_r - peak_r};
      seg_diff = {1'b0, r_r - attack_r};
      seg_den  = {1'b0, decay_r - attack_r};
    end else if (r_r < sustain_r) begin
      seg_flat = 1'b1;
    end else begin
      seg_mul  = {1'b0, hold_r};
      seg_diff = 17'h10000 - {1'b0, r_r};
      seg_den  = 17'h10000 - {1'b0, sustain_r};
    end
    seg_num = 33'(seg_mul[15:0] * seg_diff);
  end

  // Divider launch.
  always_comb begin
    div_start = 1'b0;
    div_num   = {elapsed_r, 16'd0};
    div_den   = hd_len;
    if (state_r == S_RD && mode_r) div_start = 1'b1;
    if (state_r == S_SEG && !seg_flat) begin
      div_start = 1'b1;
      div_num   = qstg_pkg::DIV_NUM_W'(seg_num);
      div_den   = qstg_pkg::DIV_DEN_W'(seg_den);
    end
  end

  // Sample scaling.
  logic [45:0] prod2;
  logic [46:0] rounded;
  logic [15:0] mag;
  assign prod2   = prod1_r * qstg_pkg::TONE_AMPLITUDE;
  assign rounded = {1'b0, prod2} + 47'h4000_0000;
  assign mag     = rounded[46:31];

  logic [LB-1:0] elapsed_inc;
  logic          note_end;
  assign elapsed_inc = elapsed_r + 1'b1;
  assign note_end    = elapsed_inc >= hd_len;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      elapsed_r   <= '0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // The output register fills from the final state and empties on a handshake.
      if (state_r == S_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            res_sample_r <= '0;
            res_done_r   <= 1'b0;
            res_acc_r    <= in_kind == qstg_pkg::KIND_PUSH && push_ok;
            res_svalid_r <= in_kind == qstg_pkg::KIND_TICK;
            state_r      <= (in_kind == qstg_pkg::KIND_TICK && count_r != '0) ? S_RD : S_OUT;
            if (in_kind == qstg_pkg::KIND_PUSH && push_ok) begin
              count_r <= count_r + 1'b1;
              tail_r  <= (tail_r == qstg_pkg::IDX_W'(qstg_pkg::QUEUE_DEPTH - 1))
                       ? '0 : tail_r + 1'b1;
            end
          end
        end
        S_RD: begin
          env_r   <= const_r;
          state_r <= mode_r ? S_DIV1 : S_GAIN;
        end
        S_DIV1: begin
          if (div_done) begin
            r_r     <= (div_quot > 40'd65535) ? 16'hFFFF : div_quot[15:0];
            state_r <= S_SEG;
          end
        end
        S_SEG: begin
          base_r  <= seg_base;
          sub_r   <= seg_sub;
          env_r   <= hold_r;
          state_r <= seg_flat ? S_GAIN : S_DIV2;
        end
        S_DIV2: begin
          if (div_done) begin
            env_r   <= sub_r ? base_r - div_quot[15:0] : base_r + div_quot[15:0];
            state_r <= S_GAIN;
          end
        end
        S_GAIN: begin
          gain_r  <= 16'((32'(hd_vol) * 32'(env_r)) >> 16);
          state_r <= S_MUL1;
        end
        S_MUL1: begin
          prod1_r <= gain_r * sine_r;
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          mag_r   <= mag[14:0];
          state_r <= S_UPD;
        end
        S_UPD: begin
          res_sample_r <= sneg_r ? -$signed({1'b0, mag_r}) : $signed({1'b0, mag_r});
          phase_r      <= phase_r + hd_step;
          if (note_end) begin
            elapsed_r  <= '0;
            head_r     <= (head_r == qstg_pkg::IDX_W'(qstg_pkg::QUEUE_DEPTH - 1))
                        ? '0 : head_r + 1'b1;
            count_r    <= count_r - 1'b1;
            res_done_r <= 1'b1;
          end else begin
            elapsed_r  <= elapsed_inc;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Output register load.
  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      o_sample_r <= res_sample_r;
      o_svalid_r <= res_svalid_r;
      o_acc_r    <= res_acc_r;
      o_done_r   <= res_done_r;
      o_count_r  <= 5'(count_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample       = o_sample_r;
  assign out_sample_valid = o_svalid_r;
  assign out_accepted     = o_acc_r;
  assign out_note_done    = o_done_r;
  assign out_queue_count  = o_count_r;

  // Checks.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= qstg_pkg::CNT_W'(qstg_pkg::QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  a_done_is_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && o_done_r |-> o_svalid_r && !o_acc_r)
    else $error("note end flagged on a push result");

  a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> o_sample_r <= 16'sd28000 && o_sample_r >= -16'sd28000)
    else $error("sample out of range");

  a_push_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !o_svalid_r |-> o_sample_r == 16'sd0)
    else $error("push result carries a sample");

endmodule
